// ===== rtl/core/spct_pkg.sv =====
// ----------------------------------------------------------------------------
// spct_pkg
// Shared types and constants for the shape point collision test.
// ----------------------------------------------------------------------------
`default_nettype none

package spct_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;

   localparam int DIST_WIDTH = 26;
   localparam logic signed [26:0] DIST_MAX = 27'sd33554431;

   // direction bits of the hit mask
   localparam logic [6:0] MASK_X_LOW  = 7'h01;
   localparam logic [6:0] MASK_X_HIGH = 7'h10;
   localparam logic [6:0] MASK_Y_LOW  = 7'h40;
   localparam logic [6:0] MASK_Y_HIGH = 7'h04;
   localparam logic [6:0] MASK_Z_LOW  = 7'h02;
   localparam logic [6:0] MASK_Z_HIGH = 7'h20;
   localparam logic [6:0] MASK_INSIDE = 7'h77;

   typedef enum logic [1:0] {
      QTR_0   = 2'd0,
      QTR_90  = 2'd1,
      QTR_180 = 2'd2,
      QTR_270 = 2'd3
   } quarter_type;

   // travels alongside the radicand through the root pipeline
   typedef struct packed {
      logic [6:0]         hit_mask;
      logic signed [15:0] half_x;
   } side_type;

endpackage

`default_nettype wire

// ===== rtl/core/spct_front.sv =====
// ----------------------------------------------------------------------------
// spct_front
// Rotation, per-axis gaps, direction mask, squares and their sum over four
// register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module spct_front #(
   parameter int COORD_WIDTH = spct_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic signed [15:0]            in_offset_x,
   input  wire logic signed [15:0]            in_offset_y,
   input  wire logic signed [15:0]            in_offset_z,
   input  wire logic signed [15:0]            in_half_x,
   input  wire logic signed [15:0]            in_half_y,
   input  wire logic signed [15:0]            in_half_z,
   input  wire logic [1:0]                    in_rotation_quarter,
   input  wire logic signed [COORD_WIDTH-1:0] in_rel_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_rel_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_rel_z,
   output logic                               out_valid,
   output logic [2*COORD_WIDTH+3:0]           out_radicand,
   output spct_pkg::side_type                 out_side
);

   localparam int MW = COORD_WIDTH + 1;       // gap magnitude
   localparam int DW = COORD_WIDTH + 2;       // signed working width
   localparam int NW = 2 * COORD_WIDTH + 4;   // sum of squares

   typedef struct packed {
      logic [MW-1:0] mag;
      logic          low;
   } gap_type;

   function automatic gap_type axis_gap(input logic signed [16:0] c,
                                        input logic signed [15:0] e,
                                        input logic signed [COORD_WIDTH-1:0] p,
                                        input logic sphere);
      logic signed [DW-1:0] cw, ew, pw, lo, hi, d;
      gap_type g;
      cw = DW'(c);
      ew = DW'(e);
      pw = DW'(p);
      lo = cw - ew;
      hi = cw + ew;
      d  = cw - pw;
      if (sphere) begin
         g.low = (d > 0);
         g.mag = (d < 0) ? MW'(-d) : MW'(d);
      end else if (pw <= lo) begin
         g.low = 1'b1;
         g.mag = MW'(lo - pw);
      end else if (pw >= hi) begin
         g.low = 1'b0;
         g.mag = MW'(pw - hi);
      end else begin
         g.low = 1'b0;
         g.mag = '0;
      end
      return g;
   endfunction

   // stage 1: rotation
   logic                          s1_valid_ff;
   logic signed [16:0]            s1_cx_ff, s1_cz_ff, s1_cy_ff;
   logic signed [15:0]            s1_ex_ff, s1_ez_ff, s1_hy_ff, s1_hx_ff;
   logic signed [COORD_WIDTH-1:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic signed [16:0]            s1_cx_in, s1_cz_in, ox17, oz17;

   assign ox17 = {in_offset_x[15], in_offset_x};
   assign oz17 = {in_offset_z[15], in_offset_z};

   always_comb begin
      case (spct_pkg::quarter_type'(in_rotation_quarter))
         spct_pkg::QTR_0: begin
            s1_cx_in = ox17;
            s1_cz_in = oz17;
         end
         spct_pkg::QTR_90: begin
            s1_cx_in = -oz17;
            s1_cz_in = ox17;
         end
         spct_pkg::QTR_180: begin
            s1_cx_in = -ox17;
            s1_cz_in = -oz17;
         end
         default: begin
            s1_cx_in = oz17;
            s1_cz_in = -ox17;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_cx_ff <= s1_cx_in;
      s1_cz_ff <= s1_cz_in;
      s1_cy_ff <= {in_offset_y[15], in_offset_y};
      // swap the X and Z extents on odd quarters
      s1_ex_ff <= in_rotation_quarter[0] ? in_half_z : in_half_x;
      s1_ez_ff <= in_rotation_quarter[0] ? in_half_x : in_half_z;
      s1_hy_ff <= in_half_y;
      s1_hx_ff <= in_half_x;
      s1_px_ff <= in_rel_x;
      s1_py_ff <= in_rel_y;
      s1_pz_ff <= in_rel_z;
   end

   // stage 2: gaps
   logic    s1_sphere;
   gap_type s2_gx_in, s2_gy_in, s2_gz_in;
   logic    s2_valid_ff, s2_sphere_ff;
   gap_type s2_gx_ff, s2_gy_ff, s2_gz_ff;
   logic signed [15:0] s2_hx_ff;

   assign s1_sphere = s1_hx_ff[15];
   assign s2_gx_in  = axis_gap(s1_cx_ff, s1_ex_ff, s1_px_ff, s1_sphere);
   assign s2_gy_in  = axis_gap(s1_cy_ff, s1_hy_ff, s1_py_ff, s1_sphere);
   assign s2_gz_in  = axis_gap(s1_cz_ff, s1_ez_ff, s1_pz_ff, s1_sphere);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_gx_ff     <= s2_gx_in;
      s2_gy_ff     <= s2_gy_in;
      s2_gz_ff     <= s2_gz_in;
      s2_sphere_ff <= s1_sphere;
      // only a sphere adds its radius back
      s2_hx_ff     <= s1_sphere ? s1_hx_ff : '0;
   end

   // stage 3: squares and mask
   logic [6:0]      bx, by, bz, s3_mask_in;
   logic [MW-1:0]   gmax;
   logic            s3_valid_ff;
   logic [2*MW-1:0] s3_sqx_ff, s3_sqy_ff, s3_sqz_ff;
   spct_pkg::side_type s3_side_ff;

   assign bx = s2_gx_ff.low ? spct_pkg::MASK_X_LOW : spct_pkg::MASK_X_HIGH;
   assign by = s2_gy_ff.low ? spct_pkg::MASK_Y_LOW : spct_pkg::MASK_Y_HIGH;
   assign bz = s2_gz_ff.low ? spct_pkg::MASK_Z_LOW : spct_pkg::MASK_Z_HIGH;

   always_comb begin
      gmax = s2_gx_ff.mag;
      if (s2_gy_ff.mag > gmax) gmax = s2_gy_ff.mag;
      if (s2_gz_ff.mag > gmax) gmax = s2_gz_ff.mag;
      if (s2_sphere_ff) begin
         s3_mask_in = bx | by | bz;
      end else if (gmax == '0) begin
         s3_mask_in = spct_pkg::MASK_INSIDE;
      end else begin
         s3_mask_in = ((s2_gx_ff.mag == gmax) ? bx : 7'h00)
                    | ((s2_gy_ff.mag == gmax) ? by : 7'h00)
                    | ((s2_gz_ff.mag == gmax) ? bz : 7'h00);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_sqx_ff           <= s2_gx_ff.mag * s2_gx_ff.mag;
      s3_sqy_ff           <= s2_gy_ff.mag * s2_gy_ff.mag;
      s3_sqz_ff           <= s2_gz_ff.mag * s2_gz_ff.mag;
      s3_side_ff.hit_mask <= s3_mask_in;
      s3_side_ff.half_x   <= s2_hx_ff;
   end

   // stage 4: sum
   logic          s4_valid_ff;
   logic [NW-1:0] s4_sum_ff;
   spct_pkg::side_type s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_sum_ff  <= NW'(s3_sqx_ff) + NW'(s3_sqy_ff) + NW'(s3_sqz_ff);
      s4_side_ff <= s3_side_ff;
   end

   assign out_valid    = s4_valid_ff;
   assign out_radicand = s4_sum_ff;
   assign out_side     = s4_side_ff;

endmodule

`default_nettype wire

// ===== rtl/core/spct_isqrt.sv =====
// ----------------------------------------------------------------------------
// spct_isqrt
// Floor square root, one root bit per register stage, side data alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module spct_isqrt #(
   parameter int RW = spct_pkg::COORD_WIDTH_DEFAULT + 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [2*RW-1:0]    in_radicand,
   input  spct_pkg::side_type      in_side,
   output logic                    out_valid,
   output logic [RW-1:0]           out_root,
   output spct_pkg::side_type      out_side
);

   localparam int NW = 2 * RW;

   logic               vld_ff  [RW];
   logic [RW-1:0]      root_ff [RW];
   spct_pkg::side_type side_ff [RW];
   logic [NW:0]        rem_ff  [RW-1];

   for (genvar j = 0; j < RW; j++) begin : g_bit
      localparam int K = RW - 1 - j;
      logic [NW:0]        rem_cur, trial;
      logic [RW-1:0]      root_cur;
      spct_pkg::side_type side_cur;
      logic               vld_cur, fits;

      if (j == 0) begin : g_first
         assign rem_cur  = {1'b0, in_radicand};
         assign root_cur = '0;
         assign side_cur = in_side;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rem_cur  = rem_ff[j-1];
         assign root_cur = root_ff[j-1];
         assign side_cur = side_ff[j-1];
         assign vld_cur  = vld_ff[j-1];
      end

      // (r + 2^K)^2 - r^2, with r holding only bits above K
      assign trial = ((NW+1)'(root_cur) << (K + 1)) | ((NW+1)'(1) << (2 * K));
      assign fits  = (rem_cur >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= vld_cur;
         end
      end

      always_ff @(posedge clock) begin
         root_ff[j] <= fits ? (root_cur | (RW'(1) << K)) : root_cur;
         side_ff[j] <= side_cur;
      end

      if (j < RW - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[j] <= fits ? (rem_cur - trial) : rem_cur;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

// ===== rtl/core/shape_point_collision_test.sv =====
// ----------------------------------------------------------------------------
// shape_point_collision_test
// Distance and direction mask of a point against a rotated sphere or box.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the shape record, quarter-turn yaw and relative position on the
//   req_ ports and raise start; the item is taken at that clock edge. busy
//   stays low, so one item may be issued in every cycle.
//   Each result appears on rsp_distance and rsp_hit_mask for exactly one
//   cycle, marked by rsp_valid, in issue order. The receiver cannot stall.
//   Stages: one for rotation, one for the axis gaps, one for squares and
//   mask, one for the sum, one per root bit in the square-root pipeline
//   (COORD_WIDTH + 2) and one for the final radius add and clamp.
//   Throughput: one item per cycle; the root pipeline sets the depth.
//   Reset clears every valid bit; items in flight are dropped and no result
//   appears until new items arrive.
// ----------------------------------------------------------------------------
`default_nettype none

module shape_point_collision_test #(
   parameter int COORD_WIDTH = spct_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [15:0]            req_offset_x,
   input  wire logic signed [15:0]            req_offset_y,
   input  wire logic signed [15:0]            req_offset_z,
   input  wire logic signed [15:0]            req_half_x,
   input  wire logic signed [15:0]            req_half_y,
   input  wire logic signed [15:0]            req_half_z,
   input  wire logic [1:0]                    req_rotation_quarter,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_z,
   output logic                               rsp_valid,
   output logic signed [25:0]                 rsp_distance,
   output logic [6:0]                         rsp_hit_mask
);

   localparam int RW = COORD_WIDTH + 2;
   localparam int NW = 2 * RW;
   localparam int SW = (RW + 1 > 27) ? RW + 1 : 27;

   logic               fr_valid;
   logic [NW-1:0]      fr_radicand;
   spct_pkg::side_type fr_side;
   logic               sq_valid;
   logic [RW-1:0]      sq_root;
   spct_pkg::side_type sq_side;

   assign busy = 1'b0;

   spct_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (start),
      .in_offset_x         (req_offset_x),
      .in_offset_y         (req_offset_y),
      .in_offset_z         (req_offset_z),
      .in_half_x           (req_half_x),
      .in_half_y           (req_half_y),
      .in_half_z           (req_half_z),
      .in_rotation_quarter (req_rotation_quarter),
      .in_rel_x            (req_rel_x),
      .in_rel_y            (req_rel_y),
      .in_rel_z            (req_rel_z),
      .out_valid           (fr_valid),
      .out_radicand        (fr_radicand),
      .out_side            (fr_side)
   );

   spct_isqrt #(
      .RW(RW)
   ) u_isqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (fr_valid),
      .in_radicand (fr_radicand),
      .in_side     (fr_side),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   // add the (negative) sphere radius, saturate on the high side only
   logic signed [SW-1:0] dist_sum;
   logic signed [25:0]   dist_in;
   logic                 valid_ff;
   logic signed [25:0]   dist_ff;
   logic [6:0]           mask_ff;

   assign dist_sum = $signed(SW'(sq_root)) + SW'(sq_side.half_x);
   assign dist_in  = (dist_sum > SW'(spct_pkg::DIST_MAX))
                   ? 26'(spct_pkg::DIST_MAX) : dist_sum[25:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      mask_ff <= sq_side.hit_mask;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_distance = dist_ff;
   assign rsp_hit_mask = mask_ff;

   // inside a box means zero distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_mask == spct_pkg::MASK_INSIDE) |-> rsp_distance == '0)
      else $error("inside mask with nonzero distance");

   // every result names at least one direction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hit_mask != '0)
      else $error("empty hit mask");

   // only a sphere can give a negative distance, and never the inside mask
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_distance[25] |-> rsp_hit_mask != spct_pkg::MASK_INSIDE)
      else $error("negative distance with inside mask");

endmodule

`default_nettype wire

// ===== bench/shape_point_collision_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_point_collision_test_checker
// Watches request and result transfers, predicts distance and mask, compares.
// ----------------------------------------------------------------------------
module shape_point_collision_test_checker #(
   parameter int COORD_WIDTH = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          busy,
   input  wire logic signed [15:0]            req_offset_x,
   input  wire logic signed [15:0]            req_offset_y,
   input  wire logic signed [15:0]            req_offset_z,
   input  wire logic signed [15:0]            req_half_x,
   input  wire logic signed [15:0]            req_half_y,
   input  wire logic signed [15:0]            req_half_z,
   input  wire logic [1:0]                    req_rotation_quarter,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_rel_z,
   input  wire logic                          rsp_valid,
   input  wire logic signed [25:0]            rsp_distance,
   input  wire logic [6:0]                    rsp_hit_mask,
   output int                                 fail_count,
   output int                                 pending_count
);
   import spct_pkg::*;

   typedef struct packed {
      logic signed [25:0] distance;
      logic [6:0]         hit_mask;
   } collision_type;

   collision_type expected_q[$];

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (n >= r + bit_v) begin
            n = n - (r + bit_v);
            r = (r >> 1) + bit_v;
         end else begin
            r = r >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [25:0] clamp_distance(longint d);
      if (d > 64'sd33554431) d = 64'sd33554431;
      return d[25:0];
   endfunction

   function automatic collision_type predict_collision(
      longint ox, longint oy, longint oz, longint hx, longint hy, longint hz,
      quarter_type q, longint px, longint py, longint pz);
      collision_type res;
      longint cx, cz, dx, dy, dz, ex, ez, gx, gy, gz, gmax;
      logic [6:0] bx, by, bz, mask;
      mask = '0;
      case (q)
         QTR_0:   begin cx = ox;  cz = oz;  end
         QTR_90:  begin cx = -oz; cz = ox;  end
         QTR_180: begin cx = -ox; cz = -oz; end
         default: begin cx = oz;  cz = -ox; end
      endcase
      if (hx < 0) begin
         dx = cx - px; dy = oy - py; dz = cz - pz;
         mask |= (dx < 1) ? MASK_X_HIGH : MASK_X_LOW;
         mask |= (dy < 1) ? MASK_Y_HIGH : MASK_Y_LOW;
         mask |= (dz < 1) ? MASK_Z_HIGH : MASK_Z_LOW;
         res.distance = clamp_distance(longint'(floor_root(dx*dx + dy*dy + dz*dz)) + hx);
         res.hit_mask = mask;
         return res;
      end
      ex = hx; ez = hz;
      if (q == QTR_90 || q == QTR_270) begin
         ex = hz; ez = hx;
      end
      if (px <= cx - ex) begin gx = cx - ex - px; bx = MASK_X_LOW; end
      else if (px >= cx + ex) begin gx = px - cx - ex; bx = MASK_X_HIGH; end
      else begin gx = 0; bx = MASK_X_HIGH; end
      if (py <= oy - hy) begin gy = oy - hy - py; by = MASK_Y_LOW; end
      else if (py >= oy + hy) begin gy = py - oy - hy; by = MASK_Y_HIGH; end
      else begin gy = 0; by = MASK_Y_HIGH; end
      if (pz <= cz - ez) begin gz = cz - ez - pz; bz = MASK_Z_LOW; end
      else if (pz >= cz + ez) begin gz = pz - cz - ez; bz = MASK_Z_HIGH; end
      else begin gz = 0; bz = MASK_Z_HIGH; end
      gmax = gx;
      if (gy > gmax) gmax = gy;
      if (gz > gmax) gmax = gz;
      if (gmax == 0) begin
         mask = MASK_INSIDE;
      end else begin
         if (gx == gmax) mask |= bx;
         if (gy == gmax) mask |= by;
         if (gz == gmax) mask |= bz;
      end
      res.distance = clamp_distance(longint'(floor_root(gx*gx + gy*gy + gz*gz)));
      res.hit_mask = mask;
      return res;
   endfunction

   always @(posedge clock) begin
      collision_type want;
      if (reset) begin
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (start && !busy)
            expected_q.push_back(predict_collision(req_offset_x, req_offset_y,
               req_offset_z, req_half_x, req_half_y, req_half_z,
               quarter_type'(req_rotation_quarter), req_rel_x, req_rel_y, req_rel_z));
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.distance !== rsp_distance || want.hit_mask !== rsp_hit_mask) begin
                  if (fail_count < 10)
                     $display("mismatch: distance exp %0d got %0d, mask exp %h got %h",
                        want.distance, rsp_distance, want.hit_mask, rsp_hit_mask);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
      end
   end
endmodule

// ===== bench/shape_point_collision_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_point_collision_test_tb
// Drives directed and random shape tests with random gaps; checker compares.
// ----------------------------------------------------------------------------
module shape_point_collision_test_tb;
   import spct_pkg::*;
   localparam int CW = 24;
   localparam int LATENCY = CW + 7;

   logic clock = 0, reset = 1, start = 0, busy, rsp_valid;
   logic signed [15:0] ox = 0, oy = 0, oz = 0, hx = 0, hy = 0, hz = 0;
   logic [1:0] rq = 0;
   logic signed [CW-1:0] px = 0, py = 0, pz = 0;
   logic signed [25:0] rsp_distance;
   logic [6:0] rsp_hit_mask;
   int fail_count, pending_count;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   shape_point_collision_test #(.COORD_WIDTH(CW)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_offset_x(ox), .req_offset_y(oy), .req_offset_z(oz),
      .req_half_x(hx), .req_half_y(hy), .req_half_z(hz),
      .req_rotation_quarter(rq), .req_rel_x(px), .req_rel_y(py), .req_rel_z(pz),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_hit_mask(rsp_hit_mask));

   shape_point_collision_test_checker #(.COORD_WIDTH(CW)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_offset_x(ox), .req_offset_y(oy), .req_offset_z(oz),
      .req_half_x(hx), .req_half_y(hy), .req_half_z(hz),
      .req_rotation_quarter(rq), .req_rel_x(px), .req_rel_y(py), .req_rel_z(pz),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance), .rsp_hit_mask(rsp_hit_mask),
      .fail_count(fail_count), .pending_count(pending_count));

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CW-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(CW-1){1'b0}}};
         1: return {1'b0, {(CW-1){1'b1}}};
         2: return CW'($signed($urandom_range(0, 200)) - 100);
         3: return CW'($signed(16'($urandom)));
         default: return CW'($urandom);
      endcase
   endfunction

   // present one item and hold it until the transfer, then drop start and idle if gap is nonzero
   task automatic issue_shape(logic [15:0] a, logic [15:0] b, logic [15:0] c,
      logic [15:0] d, logic [15:0] e, logic [15:0] f, logic [1:0] q,
      logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z, int gap);
      ox <= a; oy <= b; oz <= c; hx <= d; hy <= e; hz <= f; rq <= q;
      px <= x; py <= y; pz <= z;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      #50_000_000;
      $display("shape_point_collision_test_tb NOT OK");
      $finish;
   end

   initial begin
      int gap;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: every quarter, sphere and box, extremes, inside and ties
      for (int q = 0; q < 4; q++) begin
         issue_shape(16'd100, 16'd0, 16'd50, 16'hffd8, 16'd0, 16'd0, 2'(q),
            CW'(0), CW'(0), CW'(0), 0);
         issue_shape(16'd100, 16'd0, 16'd50, 16'd10, 16'd20, 16'd30, 2'(q),
            CW'(5), CW'(3), CW'(2), 0);
         issue_shape(16'd0, 16'd0, 16'd0, 16'd10, 16'd10, 16'd10, 2'(q),
            CW'(20), CW'(20), CW'(-20), 1);
      end
      issue_shape(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 2'd3,
         {1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, {1'b0, {(CW-1){1'b1}}}, 0);
      issue_shape(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 2'd1,
         {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, {1'b1, {(CW-1){1'b0}}}, 0);
      issue_shape(16'd0, 16'd0, 16'd0, 16'hffff, 16'd0, 16'd0, 2'd0,
         CW'(0), CW'(0), CW'(0), 0);
      issue_shape(16'd0, 16'd0, 16'd0, 16'hfff0, 16'hfff0, 16'hfff0, 2'd2,
         CW'(3), CW'(-3), CW'(0), 0);
      issue_shape(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0,
         CW'(0), CW'(0), CW'(0), 0);
      issue_shape(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 2'd0,
         CW'(1), CW'(0), CW'(0), 2);
      // hold off until every expected result has come
      start <= 0;
      while (pending_count != 0) @(negedge clock);
      for (int i = 0; i < 2000; i++) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
         if ((i / 300) % 2 == 1) gap = 0;
         issue_shape(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
            2'($urandom), pick_coord(), pick_coord(), pick_coord(), gap);
      end
      start <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 5) @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("shape_point_collision_test_tb OK");
      else
         $display("shape_point_collision_test_tb NOT OK");
      $finish;
   end
endmodule
